@@ hw/rtl/sslm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sslm_pkg
// Shared types and constants of the two-axis servo slew limiter: operation
// codes, register indexes, register reset values and the per-axis records.
// ----------------------------------------------------------------------------
package sslm_pkg;

  localparam int PULSE_W = 10;
  localparam int STEP_W  = 4;
  localparam int VALUE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ABS     = 3'd1,
    OP_REL     = 3'd2,
    OP_CENTER  = 3'd3,
    OP_INIT    = 3'd4,
    OP_RELEASE = 3'd5
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PAN_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_MID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd6;

  localparam logic [PULSE_W-1:0] RST_PAN_MIN  = 10'd28;
  localparam logic [PULSE_W-1:0] RST_PAN_MID  = 10'd75;
  localparam logic [PULSE_W-1:0] RST_PAN_MAX  = 10'd122;
  localparam logic [PULSE_W-1:0] RST_TILT_MIN = 10'd58;
  localparam logic [PULSE_W-1:0] RST_TILT_MID = 10'd90;
  localparam logic [PULSE_W-1:0] RST_TILT_MAX = 10'd122;
  localparam logic [STEP_W-1:0]  RST_STEP     = 4'd1;

  // Largest value the pulse fields can carry.
  localparam int PULSE_FIELD_MAX = (1 << PULSE_W) - 1;

  typedef struct packed {
    logic [PULSE_W-1:0] pan_min;
    logic [PULSE_W-1:0] pan_mid;
    logic [PULSE_W-1:0] pan_max;
    logic [PULSE_W-1:0] tilt_min;
    logic [PULSE_W-1:0] tilt_mid;
    logic [PULSE_W-1:0] tilt_max;
    logic [STEP_W-1:0]  step;
  } cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] now;
    logic [PULSE_W-1:0] goal;
    logic               written;
  } axis_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/sslm_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sslm_regs
// Configuration register file: limits, middle values and step limit.
// ----------------------------------------------------------------------------
module sslm_regs
  import sslm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_PAN_MIN:  cfg_nxt.pan_min  = wr_data;
        CFG_PAN_MID:  cfg_nxt.pan_mid  = wr_data;
        CFG_PAN_MAX:  cfg_nxt.pan_max  = wr_data;
        CFG_TILT_MIN: cfg_nxt.tilt_min = wr_data;
        CFG_TILT_MID: cfg_nxt.tilt_mid = wr_data;
        CFG_TILT_MAX: cfg_nxt.tilt_max = wr_data;
        CFG_STEP:     cfg_nxt.step     = wr_data[STEP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_min  <= RST_PAN_MIN;
      cfg_r.pan_mid  <= RST_PAN_MID;
      cfg_r.pan_max  <= RST_PAN_MAX;
      cfg_r.tilt_min <= RST_TILT_MIN;
      cfg_r.tilt_mid <= RST_TILT_MID;
      cfg_r.tilt_max <= RST_TILT_MAX;
      cfg_r.step     <= RST_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hw/rtl/sslm_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sslm_axis
// Next position, goal and written flag of one axis for one request.
// ----------------------------------------------------------------------------
module sslm_axis
  import sslm_pkg::*;
(
  input  wire op_t                  op,
  input  wire logic                 ready,
  input  wire logic [VALUE_W-1:0]   value,
  input  wire logic [PULSE_W-1:0]   now,
  input  wire logic [PULSE_W-1:0]   goal,
  input  wire logic [PULSE_W-1:0]   middle,
  input  wire logic [PULSE_W-1:0]   minimum,
  input  wire logic [PULSE_W-1:0]   maximum,
  input  wire logic [STEP_W-1:0]    step,
  input  wire logic [PULSE_W-1:0]   pulse_cap,
  output axis_res_t                 res
);

  localparam int WIDE_W = VALUE_W + 2;

  logic signed [WIDE_W-1:0] value_s;
  logic signed [WIDE_W-1:0] now_s;
  logic signed [WIDE_W-1:0] lo_s;
  logic signed [WIDE_W-1:0] hi_s;
  logic signed [WIDE_W-1:0] cap_s;
  logic signed [WIDE_W-1:0] want;
  logic signed [WIDE_W-1:0] lim;
  logic [PULSE_W-1:0]       limited;
  logic [PULSE_W-1:0]       step_w;
  logic [PULSE_W-1:0]       stepped;
  logic [PULSE_W-1:0]       init_val;

  assign value_s = {{(WIDE_W-VALUE_W){value[VALUE_W-1]}}, value};
  assign now_s   = {{(WIDE_W-PULSE_W){1'b0}}, now};
  assign lo_s    = {{(WIDE_W-PULSE_W){1'b0}}, minimum};
  assign hi_s    = {{(WIDE_W-PULSE_W){1'b0}}, maximum};
  assign cap_s   = {{(WIDE_W-PULSE_W){1'b0}}, pulse_cap};
  assign step_w  = {{(PULSE_W-STEP_W){1'b0}}, step};

  // Goal candidate: raise to minimum, lower to maximum, cap, then floor at zero.
  always_comb begin
    case (op)
      OP_ABS:    want = value_s;
      OP_REL:    want = now_s + value_s;
      default:   want = {{(WIDE_W-PULSE_W){1'b0}}, middle};
    endcase
    lim = want;
    if (lim < lo_s)  lim = lo_s;
    if (lim > hi_s)  lim = hi_s;
    if (lim > cap_s) lim = cap_s;
    if (lim < 0)     lim = '0;
    limited = lim[PULSE_W-1:0];
  end

  // Slew toward the goal by at most the step limit.
  always_comb begin
    if (now < goal) begin
      stepped = ((goal - now) > step_w) ? now + step_w : goal;
    end else if (now > goal) begin
      stepped = ((now - goal) > step_w) ? now - step_w : goal;
    end else begin
      stepped = now;
    end
  end

  assign init_val = (middle > pulse_cap) ? pulse_cap : middle;

  always_comb begin
    res.now     = now;
    res.goal    = goal;
    res.written = 1'b0;
    case (op)
      OP_TICK: begin
        if (ready) begin
          res.now     = stepped;
          res.written = (stepped != now);
        end
      end
      OP_ABS, OP_REL, OP_CENTER: begin
        if (ready) begin
          res.goal = limited;
        end
      end
      OP_INIT: begin
        if (!ready) begin
          res.now     = init_val;
          res.goal    = init_val;
          res.written = 1'b1;
        end
      end
      OP_RELEASE: begin
        res.written = ready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/two_axis_servo_slew_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_servo_slew_limiter
// Pan/tilt servo position ramp with per-tick slew limit.
//
// Input channel (in_valid/in_stall): one request per item - tick, move
// absolute, move relative, center, initialize or release - with signed pan
// and tilt operands. Result channel (out_valid/out_stall): exactly one result
// per request with both pulse values, the written flags, at_target and status.
// Configuration channel (cfg_valid/cfg_ready): limits, middle values and step
// limit by register index; cfg_ready is always high. Write only while idle.
//
// Path: a taken request waits in the input register, passes the combinational
// axis logic and lands in the result register, where the receiver takes it.
// Throughput: one request per cycle while the receiver does not stall; the
// single-pass axis logic between the two registers allows that rate.
// Reset: positions and goals go to the middle values, the block is not
// initialized, registers return to their defaults, both registers empty.
// Receiver stall: the result register holds; the input register holds its
// request and in_stall rises only while both stages are full.
// ----------------------------------------------------------------------------
module two_axis_servo_slew_limiter
  import sslm_pkg::*;
#(
  parameter int PULSE_RANGE = 1000
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_operation,
  input  wire logic [VALUE_W-1:0]    in_pan_value,
  input  wire logic [VALUE_W-1:0]    in_tilt_value,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PULSE_W-1:0]         out_pan_pulse,
  output logic [PULSE_W-1:0]         out_tilt_pulse,
  output logic                       out_pan_written,
  output logic                       out_tilt_written,
  output logic                       out_at_target,
  output logic                       out_status,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Highest legal pulse value, bounded by the field width.
  localparam int CAP_INT = (PULSE_RANGE - 1 > PULSE_FIELD_MAX) ?
                           PULSE_FIELD_MAX : PULSE_RANGE - 1;
  localparam logic [PULSE_W-1:0] PULSE_CAP = CAP_INT[PULSE_W-1:0];

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  sslm_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // --------------------------------------------------------------------------
  // Handshake: the result register blocks when full and stalled; the input
  // register then holds and back-pressures the requester.
  // --------------------------------------------------------------------------
  logic out_blocked;
  logic advance;

  logic               s1_valid_r, s1_valid_nxt;
  op_t                s1_op_r;
  logic [VALUE_W-1:0] s1_pan_r;
  logic [VALUE_W-1:0] s1_tilt_r;

  assign out_blocked = out_valid && out_stall;
  assign in_stall    = s1_valid_r && out_blocked;
  assign advance     = s1_valid_r && !out_blocked;

  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the request payload whenever the stage is free to take one.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r   <= op_t'(in_operation);
      s1_pan_r  <= in_pan_value;
      s1_tilt_r <= in_tilt_value;
    end
  end

  // --------------------------------------------------------------------------
  // Servo state
  // --------------------------------------------------------------------------
  logic [PULSE_W-1:0] pan_now_r, tilt_now_r, pan_goal_r, tilt_goal_r;
  logic               ready_r, ready_nxt;
  axis_res_t          pan_res, tilt_res;
  logic               motion;
  logic               refused;

  sslm_axis u_pan (
    .op        (s1_op_r),
    .ready     (ready_r),
    .value     (s1_pan_r),
    .now       (pan_now_r),
    .goal      (pan_goal_r),
    .middle    (cfg.pan_mid),
    .minimum   (cfg.pan_min),
    .maximum   (cfg.pan_max),
    .step      (cfg.step),
    .pulse_cap (PULSE_CAP),
    .res       (pan_res)
  );

  sslm_axis u_tilt (
    .op        (s1_op_r),
    .ready     (ready_r),
    .value     (s1_tilt_r),
    .now       (tilt_now_r),
    .goal      (tilt_goal_r),
    .middle    (cfg.tilt_mid),
    .minimum   (cfg.tilt_min),
    .maximum   (cfg.tilt_max),
    .step      (cfg.step),
    .pulse_cap (PULSE_CAP),
    .res       (tilt_res)
  );

  // Motion requests are refused until the servos are initialized.
  assign motion  = (s1_op_r == OP_TICK) || (s1_op_r == OP_ABS) ||
                   (s1_op_r == OP_REL)  || (s1_op_r == OP_CENTER);
  assign refused = motion && !ready_r;

  always_comb begin
    ready_nxt = ready_r;
    case (s1_op_r)
      OP_INIT:    ready_nxt = 1'b1;
      OP_RELEASE: ready_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_now_r   <= RST_PAN_MID;
      tilt_now_r  <= RST_TILT_MID;
      pan_goal_r  <= RST_PAN_MID;
      tilt_goal_r <= RST_TILT_MID;
      ready_r     <= 1'b0;
    end else if (advance) begin
      pan_now_r   <= pan_res.now;
      tilt_now_r  <= tilt_res.now;
      pan_goal_r  <= pan_res.goal;
      tilt_goal_r <= tilt_res.goal;
      ready_r     <= ready_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: advance when not blocked, hold otherwise.
  // --------------------------------------------------------------------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_blocked) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_blocked) begin
      out_pan_pulse    <= ready_nxt ? pan_res.now  : '0;
      out_tilt_pulse   <= ready_nxt ? tilt_res.now : '0;
      out_pan_written  <= pan_res.written;
      out_tilt_written <= tilt_res.written;
      out_at_target    <= ready_nxt && (pan_res.now == pan_res.goal) &&
                          (tilt_res.now == tilt_res.goal);
      out_status       <= refused;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
